// ----- hw/rtl/sxr_pkg.sv -----
// ============================================================================
// sxr_pkg: shared definitions for the strip crosstalk redistribution block
// Widths, constants and the structs that travel between the front part, the
// back part, the strip store and the divider.
// ============================================================================
package sxr_pkg;

    // Largest number of strips in one event.
    localparam int MAX_STRIPS = 64;

    // Field widths.
    localparam int CHARGE_W = 24;
    localparam int POS_W    = 16;
    localparam int PCT_W    = 7;

    // Strip index within one bank, strip count, and store address (bank + index).
    localparam int IDX_W  = $clog2(MAX_STRIPS);
    localparam int CNT_W  = $clog2(MAX_STRIPS + 1);
    localparam int ADDR_W = IDX_W + 1;

    // Divider and product widths: peak * percent fits in DIV_W bits.
    localparam int DIV_W      = CHARGE_W + PCT_W;
    localparam int DVSR_W     = (PCT_W > CNT_W) ? PCT_W : CNT_W;
    localparam int DIV_STEP_W = $clog2(DIV_W);

    // Division by 100 as a multiply by the rounded-up reciprocal of 100 scaled
    // by 2^37, followed by a right shift of 37. Exact for dividends below 2^32.
    localparam int                 RECIP_W         = 32;
    localparam int                 PCT_RECIP_SHIFT = 37;
    localparam logic [RECIP_W-1:0] PCT_RECIP       = 32'h51EB_851F;

    // Event queue between the front and back parts, one entry per store bank.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Percent limits.
    localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
    localparam logic [PCT_W-1:0] LEAK_RESET = PCT_W'(1);

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_LEAK_ADDR = APB_ADDR_W'(0);

    // One stored strip.
    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
    } strip_t;

    // Store write port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        strip_t            data;
    } store_wr_t;

    // Store read port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    // A closed event, ready for emission.
    typedef struct packed {
        logic                bank;
        logic [CNT_W-1:0]    cnt;
        logic [CHARGE_W-1:0] peak;
        logic [CHARGE_W-1:0] loss;
        logic [CHARGE_W-1:0] share;
    } evt_desc_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Front part sequencer.
    typedef enum logic [2:0] {
        F_LOAD,
        F_LOSS,
        F_LOSS_WAIT,
        F_SHARE,
        F_SHARE_WAIT,
        F_PUSH
    } front_state_t;

endpackage

// ----- hw/rtl/strip_crosstalk_redistribute.sv -----
// ============================================================================
// strip_crosstalk_redistribute: detector strip crosstalk redistribution
// Intake takes one strip per cycle into a free store bank while in_ready is high.
// After the strip that closes an event, the peak loss is scaled through a product
// register and the reciprocal, the share is divided out (no division with at
// most one non-zero strip) and the event is handed to emission. Strips are read
// back one at a time, a new read only after the last one returned, through the
// store's registered read port; a bank's next event loads while the other emits.
// Reset clears all control state and sets leak_percent to 1; the strip store
// is not cleared and needs no clearing pass.
// ============================================================================
module strip_crosstalk_redistribute (
    input  logic                            clk,
    input  logic                            rst_n,
    // Strip intake
    input  logic [sxr_pkg::CHARGE_W-1:0]    charge,
    input  logic [sxr_pkg::POS_W-1:0]       pos_x,
    input  logic [sxr_pkg::POS_W-1:0]       pos_y,
    input  logic                            last,
    input  logic                            in_valid,
    output logic                            in_ready,
    // Corrected strips
    output logic [sxr_pkg::CHARGE_W-1:0]    out_charge,
    output logic [sxr_pkg::POS_W-1:0]       out_x,
    output logic [sxr_pkg::POS_W-1:0]       out_y,
    output logic                            out_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sxr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sxr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sxr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sxr_pkg::*;

    logic [PCT_W-1:0] leak_percent_reg;
    logic             cfg_wr;

    logic      evt_push;
    evt_desc_t evt;
    logic      q_full;
    store_wr_t store_wr;
    store_rd_t store_rd;
    strip_t    rd_data;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // Configuration register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_LEAK_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_percent_reg <= LEAK_RESET;
        end
        else if (cfg_wr)
        begin
            leak_percent_reg <= pwdata[PCT_W-1:0];
        end
    end

    // Read-back.
    always_comb
    begin
        prdata = '0;
        if (paddr == REG_LEAK_ADDR)
        begin
            prdata = APB_DATA_W'(leak_percent_reg);
        end
    end

    // Intake and event close.
    sxr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .charge       (charge),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last         (last),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .leak_percent (leak_percent_reg),
        .q_full       (q_full),
        .evt_push     (evt_push),
        .evt          (evt),
        .wr           (store_wr),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    // Divider for the front part's share.
    sxr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Two-bank strip store.
    sxr_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (rd_data)
    );

    // Emission.
    sxr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_push   (evt_push),
        .evt        (evt),
        .q_full     (q_full),
        .rd         (store_rd),
        .rd_data    (rd_data),
        .out_charge (out_charge),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_last   (out_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ----- hw/rtl/sxr_div.sv -----
// ============================================================================
// sxr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Used for the per-strip
// share (loss / (non-zero count - 1)).
// ============================================================================
module sxr_div (
    input  logic             clk,
    input  logic             rst_n,
    input  sxr_pkg::div_req_t req,
    output sxr_pkg::div_rsp_t rsp
);
    import sxr_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [DVSR_W-1:0]     rem_reg, rem_next;
    logic [DVSR_W-1:0]     dvsr_reg, dvsr_next;

    logic [DVSR_W:0] shifted;
    logic [DVSR_W:0] diff;
    logic            ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign ge      = (shifted >= {1'b0, dvsr_reg});

    // Step control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
            step_next = step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef ASSERT_OFF
    // A new division is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

// ----- hw/rtl/sxr_store.sv -----
// ============================================================================
// sxr_store: two-bank strip store
// One bank is filled by the front part while the other is read by the back
// part. One write port and one registered read port.
// ============================================================================
module sxr_store (
    input  logic               clk,
    input  sxr_pkg::store_wr_t wr,
    input  sxr_pkg::store_rd_t rd,
    output sxr_pkg::strip_t    rd_data
);
    import sxr_pkg::*;

    strip_t mem [0:(2**ADDR_W)-1];
    strip_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sxr_front.sv -----
// ============================================================================
// sxr_front: strip intake
// Writes incoming strips into the current store bank, tracks the peak charge
// and the non-zero count, and on close scales the peak loss with a reciprocal
// multiply and divides out the share before handing the event to the back part.
// ============================================================================
module sxr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sxr_pkg::CHARGE_W-1:0]  charge,
    input  logic [sxr_pkg::POS_W-1:0]     pos_x,
    input  logic [sxr_pkg::POS_W-1:0]     pos_y,
    input  logic                          last,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sxr_pkg::PCT_W-1:0]     leak_percent,
    input  logic                          q_full,
    output logic                          evt_push,
    output sxr_pkg::evt_desc_t            evt,
    output sxr_pkg::store_wr_t            wr,
    output sxr_pkg::div_req_t             div_req,
    input  sxr_pkg::div_rsp_t             div_rsp
);
    import sxr_pkg::*;

    front_state_t        state_reg, state_next;
    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    nz_reg, nz_next;
    logic [CHARGE_W-1:0] peak_reg, peak_next;
    logic [CHARGE_W-1:0] loss_reg, loss_next;
    logic [CHARGE_W-1:0] share_reg, share_next;
    logic [DIV_W-1:0]    prod_reg, prod_next;

    logic                     accept;
    logic [CNT_W-1:0]         fill_inc;
    logic [PCT_W-1:0]         pct_clamp;
    logic [DIV_W-1:0]         loss_prod;
    logic [DIV_W+RECIP_W-1:0] loss_scaled;

    // Intake is open while loading and a store bank is free.
    assign in_ready = (state_reg == F_LOAD) && !q_full;
    assign accept   = in_valid && in_ready;
    assign fill_inc = fill_reg + CNT_W'(1);

    // Percentages above full scale act as full scale.
    assign pct_clamp = (leak_percent > PCT_FULL) ? PCT_FULL : leak_percent;
    assign loss_prod = {{PCT_W{1'b0}}, peak_reg} * {{CHARGE_W{1'b0}}, pct_clamp};

    // Registered product divided by 100 through the reciprocal.
    assign loss_scaled = {{RECIP_W{1'b0}}, prod_reg} * {{DIV_W{1'b0}}, PCT_RECIP};

    // Store write of the accepted strip.
    assign wr.en   = accept;
    assign wr.addr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wr.data = '{charge: charge, pos_x: pos_x, pos_y: pos_y};

    // Event descriptor handed to the back part.
    assign evt = '{bank: bank_reg, cnt: fill_reg, peak: peak_reg,
                   loss: loss_reg, share: share_reg};

    // Sequencer: load, scale the loss, divide out a share if nz > 1, hand over.
    always_comb
    begin
        state_next       = state_reg;
        bank_next        = bank_reg;
        fill_next        = fill_reg;
        nz_next          = nz_reg;
        peak_next        = peak_reg;
        loss_next        = loss_reg;
        share_next       = share_reg;
        prod_next        = prod_reg;
        evt_push         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            F_LOAD:
            begin
                if (accept)
                begin
                    peak_next = (charge > peak_reg) ? charge : peak_reg;
                    nz_next   = nz_reg + CNT_W'(charge != '0);
                    fill_next = fill_inc;
                    if (last || (fill_inc == CNT_W'(MAX_STRIPS)))
                    begin
                        state_next = F_LOSS;
                    end
                end
            end
            F_LOSS:
            begin
                prod_next  = loss_prod;
                state_next = F_LOSS_WAIT;
            end
            F_LOSS_WAIT:
            begin
                loss_next = loss_scaled[PCT_RECIP_SHIFT +: CHARGE_W];
                if (nz_reg > CNT_W'(1))
                begin
                    state_next = F_SHARE;
                end
                else
                begin
                    share_next = '0;
                    state_next = F_PUSH;
                end
            end
            F_SHARE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {{PCT_W{1'b0}}, loss_reg};
                div_req.divisor  = DVSR_W'(nz_reg - CNT_W'(1));
                state_next       = F_SHARE_WAIT;
            end
            F_SHARE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    share_next = div_rsp.quotient[CHARGE_W-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                // A bank was free when the event started, so the queue has room.
                evt_push   = 1'b1;
                bank_next  = !bank_reg;
                fill_next  = '0;
                nz_next    = '0;
                peak_next  = '0;
                state_next = F_LOAD;
            end
            default:
            begin
                state_next = F_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_LOAD;
            bank_reg  <= 1'b0;
            fill_reg  <= '0;
            nz_reg    <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            fill_reg  <= fill_next;
            nz_reg    <= nz_next;
            peak_reg  <= peak_next;
        end
    end

    // Loss and share results.
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        loss_reg  <= loss_next;
        share_reg <= share_next;
    end

`ifndef ASSERT_OFF
    // The divider only answers while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == F_SHARE_WAIT))
        else $error("divider result arrived outside a wait state");
`endif

endmodule

// ----- hw/rtl/sxr_back.sv -----
// ============================================================================
// sxr_back: strip emission
// Holds closed events in a two-entry queue, reads their strips back from the
// store in order, applies the crosstalk correction and drives the result
// through an output register.
// ============================================================================
module sxr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_push,
    input  sxr_pkg::evt_desc_t            evt,
    output logic                          q_full,
    output sxr_pkg::store_rd_t            rd,
    input  sxr_pkg::strip_t               rd_data,
    output logic [sxr_pkg::CHARGE_W-1:0]  out_charge,
    output logic [sxr_pkg::POS_W-1:0]     out_x,
    output logic [sxr_pkg::POS_W-1:0]     out_y,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import sxr_pkg::*;

    // Event queue.
    evt_desc_t         q_mem_reg [0:Q_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] q_cnt_reg;
    evt_desc_t         head;
    logic              q_empty;
    logic              pop;

    // Read sequencing.
    logic [IDX_W-1:0] idx_reg;
    logic             rd_pend_reg;
    logic             rd_last_reg;
    logic             issue;
    logic             idx_is_last;

    // Correction datapath and output register.
    logic [CHARGE_W:0]   sum;
    logic [CHARGE_W-1:0] corr;
    logic [CHARGE_W-1:0] out_charge_reg;
    logic [POS_W-1:0]    out_x_reg;
    logic [POS_W-1:0]    out_y_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    assign head    = q_mem_reg[rd_ptr_reg];
    assign q_empty = (q_cnt_reg == '0);
    assign q_full  = (q_cnt_reg == QCNT_W'(Q_DEPTH));

    // A read is issued only when its result has a free output slot.
    assign idx_is_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == head.cnt);
    assign issue = !q_empty && !rd_pend_reg && (!out_valid_reg || out_ready);
    assign pop   = rd_pend_reg && rd_last_reg;

    assign rd.en   = issue;
    assign rd.addr = {head.bank, idx_reg};

    // Queue pointers; the head entry is kept until its last strip is read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (evt_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (evt_push && !pop)
            begin
                q_cnt_reg <= q_cnt_reg + QCNT_W'(1);
            end
            else if (pop && !evt_push)
            begin
                q_cnt_reg <= q_cnt_reg - QCNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (evt_push)
        begin
            q_mem_reg[wr_ptr_reg] <= evt;
        end
    end

    // Strip index and read tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= issue;
            if (issue)
            begin
                rd_last_reg <= idx_is_last;
                idx_reg     <= idx_is_last ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    // Crosstalk correction: peak strips lose, zero strips stay, others gain.
    assign sum = {1'b0, rd_data.charge} + {1'b0, head.share};
    always_comb
    begin
        if (rd_data.charge == head.peak)
        begin
            corr = head.peak - head.loss;
        end
        else if (rd_data.charge == '0)
        begin
            corr = '0;
        end
        else if (sum[CHARGE_W])
        begin
            corr = CHARGE_MAX;
        end
        else
        begin
            corr = sum[CHARGE_W-1:0];
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd_pend_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_charge_reg <= corr;
            out_x_reg      <= rd_data.pos_x;
            out_y_reg      <= rd_data.pos_y;
            out_last_reg   <= rd_last_reg;
        end
    end

    assign out_charge = out_charge_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_last   = out_last_reg;
    assign out_valid  = out_valid_reg;

`ifndef ASSERT_OFF
    // The front part never hands over an event with both banks in use.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        evt_push |-> !q_full)
        else $error("event queue overflow");

    // Read data always belongs to a queued event.
    a_read_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !q_empty)
        else $error("store read without a queued event");

    // Returning read data always finds the output register free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("read data would overwrite a waiting result");
`endif

endmodule

// ----- sim/tb_strip_crosstalk_redistribute.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strip_crosstalk_redistribute: self-checking bench for strip crosstalk
// Sends detector strip events through the intake channel and predicts each
// corrected strip from its own copy of the event store and leak setting.
// Every emitted strip is compared field by field with the oldest prediction.
// The bench changes the leak percent between events over the APB port, runs
// with random stalls on both sides, with a long output hold-off and with a
// stretch that has no stalls at all.
// ----------------------------------------------------------------------------
module tb_strip_crosstalk_redistribute;

    import sxr_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    // One share division of 31 steps plus the store read path.
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 700;

    // One strip, as sent or as expected back.
    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic                last;
    } strip_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic [CHARGE_W-1:0]   charge = '0;
    logic [POS_W-1:0]      pos_x = '0;
    logic [POS_W-1:0]      pos_y = '0;
    logic                  last = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CHARGE_W-1:0]   out_charge;
    logic [POS_W-1:0]      out_x;
    logic [POS_W-1:0]      out_y;
    logic                  out_last;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Requests waiting to be sent and corrected strips waiting to come back.
    strip_rec_t intake_q[$];
    strip_rec_t corrected_q[$];
    strip_rec_t next_strip;
    strip_rec_t want;

    // Predictor copy of the event store and the leak setting.
    strip_t              evt_strip [MAX_STRIPS];
    logic [CHARGE_W-1:0] evt_peak = '0;
    int                  evt_nonzero = 0;
    int                  evt_fill = 0;
    logic [PCT_W-1:0]    leak_pct = LEAK_RESET;

    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;
    int   hold_left = 0;
    logic no_idle = 1'b0;
    logic in_taken = 1'b0;

    strip_crosstalk_redistribute u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .charge     (charge),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .last       (last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_charge (out_charge),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_last   (out_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                 cycle_cnt, what, got, exp_val);
        mismatch_cnt++;
    endtask

    // Take one strip into the predicted event; when the event closes, work out
    // the corrected charge of every stored strip.
    task automatic absorb_strip(input strip_rec_t s);
        logic [PCT_W-1:0]    pct;
        logic [DIV_W-1:0]    loss;
        logic [DIV_W-1:0]    share;
        logic [CHARGE_W:0]   sum;
        logic [CHARGE_W-1:0] v;
        strip_rec_t          r;
        int                  k;
        evt_strip[evt_fill] = '{charge: s.charge, pos_x: s.x, pos_y: s.y};
        if (s.charge > evt_peak)
            evt_peak = s.charge;
        if (s.charge != '0)
            evt_nonzero++;
        evt_fill++;
        if (s.last || evt_fill == MAX_STRIPS)
        begin
            // Percent values above 100 act as 100.
            pct   = (leak_pct > PCT_FULL) ? PCT_FULL : leak_pct;
            loss  = (DIV_W'(evt_peak) * DIV_W'(pct)) / DIV_W'(100);
            // With at most one non-zero strip nothing is shared out.
            share = (evt_nonzero > 1) ? loss / DIV_W'(evt_nonzero - 1) : '0;
            for (k = 0; k < evt_fill; k++)
            begin
                v = evt_strip[k].charge;
                if (v == evt_peak)
                    r.charge = evt_peak - loss[CHARGE_W-1:0];
                else if (v == '0)
                    r.charge = '0;
                else
                begin
                    sum = (CHARGE_W + 1)'(v) + share[CHARGE_W:0];
                    r.charge = sum[CHARGE_W] ? CHARGE_MAX : sum[CHARGE_W-1:0];
                end
                r.x    = evt_strip[k].pos_x;
                r.y    = evt_strip[k].pos_y;
                r.last = (k == evt_fill - 1);
                corrected_q.push_back(r);
            end
            evt_peak    = '0;
            evt_nonzero = 0;
            evt_fill    = 0;
        end
    endtask

    // Accept side: feed accepted requests to the predictor and check results.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            absorb_strip('{charge: charge, x: pos_x, y: pos_y, last: last});
            in_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (corrected_q.size() == 0)
                flag_mismatch("unexpected strip, charge", 32'(out_charge), 32'hFFFF_FFFF);
            else
            begin
                want = corrected_q.pop_front();
                if (out_charge !== want.charge)
                    flag_mismatch("out_charge", 32'(out_charge), 32'(want.charge));
                if (out_x !== want.x)
                    flag_mismatch("out_x", 32'(out_x), 32'(want.x));
                if (out_y !== want.y)
                    flag_mismatch("out_y", 32'(out_y), 32'(want.y));
                if (out_last !== want.last)
                    flag_mismatch("out_last", 32'(out_last), 32'(want.last));
            end
        end
    end

    // Sender: next request after the previous one was taken, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (intake_q.size() != 0 && (no_idle || $urandom_range(99) >= 10))
            begin
                next_strip = intake_q.pop_front();
                charge   <= next_strip.charge;
                pos_x    <= next_strip.x;
                pos_y    <= next_strip.y;
                last     <= next_strip.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(99) >= 10);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("FAIL strip_crosstalk_redistribute");
            $finish;
        end
    end

    // Configuration writes: setup cycle, then access cycle.
    task automatic write_leak(input logic [PCT_W-1:0] pct);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LEAK_ADDR;
        pwdata  <= APB_DATA_W'(pct);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        leak_pct = pct;
    endtask

    // Read the leak register back and compare with the predictor's copy.
    task automatic check_leak();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_LEAK_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(leak_pct))
            flag_mismatch("leak_percent readback", prdata, 32'(leak_pct));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_strip(input logic [CHARGE_W-1:0] c, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic lst);
        intake_q.push_back('{charge: c, x: x, y: y, last: lst});
    endtask

    // Mostly short events, some long ones, a few that fill or overrun the store.
    function automatic int pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom_range(1, 8);
        else if (roll < 85)
            return $urandom_range(9, 30);
        else if (roll < 95)
            return $urandom_range(31, 63);
        return $urandom_range(64, 70);
    endfunction

    // One event of random strips; many strips tie on a common value.
    // Strips past the store size start a new event that ends with last.
    task automatic queue_event(input int len);
        logic [CHARGE_W-1:0] tie;
        logic [CHARGE_W-1:0] c;
        int                  i;
        int                  roll;
        tie = ($urandom_range(1) == 0) ? CHARGE_W'($urandom) : CHARGE_W'($urandom_range(4095));
        for (i = 0; i < len; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
                c = '0;
            else if (roll < 45)
                c = tie;
            else if (roll < 55)
                c = CHARGE_MAX - CHARGE_W'($urandom_range(15));
            else if (roll < 70)
                c = CHARGE_W'($urandom_range(255));
            else
                c = CHARGE_W'($urandom);
            push_strip(c, POS_W'($urandom), POS_W'($urandom), i == len - 1);
        end
    endtask

    task automatic queue_random(input int target);
        int added;
        int len;
        added = 0;
        while (added < target)
        begin
            len = pick_len();
            queue_event(len);
            added += len;
        end
    endtask

    // Sender pause: wait until every request is sent and every strip is back.
    task automatic wait_drained();
        while (intake_q.size() != 0 || in_valid || corrected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reset value of the leak register.
        check_leak();

        // Directed events at the reset leak setting.
        // Single strip at full scale: nothing to share.
        push_strip(CHARGE_MAX, 16'hFFFF, 16'h0000, 1'b1);
        // All strips zero.
        push_strip('0, 16'h0000, 16'hFFFF, 1'b0);
        push_strip('0, 16'h8001, 16'h7FFE, 1'b1);
        // Neighbor just below full scale saturates after its share.
        push_strip(CHARGE_MAX - 1, 16'h0001, 16'h0002, 1'b0);
        push_strip(CHARGE_MAX, 16'h0003, 16'h0004, 1'b1);
        // Two strips tie for the peak, with a zero strip between.
        push_strip(24'd1000, 16'h0010, 16'h0020, 1'b0);
        push_strip('0, 16'h0011, 16'h0021, 1'b0);
        push_strip(24'd1000, 16'h0012, 16'h0022, 1'b0);
        push_strip(24'd500, 16'h0013, 16'h0023, 1'b1);
        // One non-zero strip among zeros.
        push_strip('0, 16'h1234, 16'h4321, 1'b0);
        push_strip(24'd300, 16'h5678, 16'h8765, 1'b0);
        push_strip('0, 16'h9ABC, 16'hCBA9, 1'b1);
        // Single zero strip.
        push_strip('0, 16'hFFFF, 16'hFFFF, 1'b1);
        // Tiny charges: the loss rounds down to zero.
        push_strip(24'd1, 16'h0000, 16'h0000, 1'b0);
        push_strip(24'd2, 16'h0001, 16'h0001, 1'b0);
        push_strip(24'd3, 16'h0002, 16'h0002, 1'b0);
        push_strip(24'd4, 16'h0003, 16'h0003, 1'b1);
        // Alternating bit patterns.
        push_strip(24'hAAAAAA, 16'hAAAA, 16'h5555, 1'b0);
        push_strip(24'h555555, 16'h5555, 16'hAAAA, 1'b1);
        wait_drained();

        // No leak at all.
        write_leak(PCT_W'(0));
        check_leak();
        queue_random(25);
        wait_drained();

        // Full leak.
        write_leak(PCT_FULL);
        check_leak();
        queue_random(25);
        wait_drained();

        // Top code, acts as full leak. The receiver holds off while full
        // events keep arriving, so both banks fill and the intake stalls.
        write_leak(PCT_W'(127));
        check_leak();
        hold_left = HOLD_CYCLES;
        queue_event(64);
        queue_event(64);
        queue_event(12);
        wait_drained();

        // Just above full, with no stalls on either side.
        write_leak(PCT_W'(101));
        check_leak();
        no_idle = 1'b1;
        queue_random(40);
        wait_drained();
        no_idle = 1'b0;

        // A random setting inside the range.
        write_leak(PCT_W'($urandom_range(2, 99)));
        check_leak();
        queue_random(20);
        wait_drained();

        // Back to the smallest non-zero leak.
        write_leak(LEAK_RESET);
        check_leak();
        queue_random(20);
        wait_drained();

        if (mismatch_cnt == 0)
            $display("PASS strip_crosstalk_redistribute");
        else
            $display("FAIL strip_crosstalk_redistribute");
        $finish;
    end

endmodule
